/* hdl/segment_address_translate_assert.svh */
// Assertion macros for the segment address translation block
`ifndef SEGMENT_ADDRESS_TRANSLATE_ASSERT_SVH
`define SEGMENT_ADDRESS_TRANSLATE_ASSERT_SVH

`ifndef ASSERT_OFF
// check a property on every clock edge outside reset
`define SAT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check a property on every clock edge, reset included
`define SAT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SAT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SAT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* hdl/sat_pkg.sv */
// Types and constants shared by the segment address translation block
`default_nettype none
package sat_pkg;

  localparam int SEG_COUNT  = 16;
  localparam int SEG_IDX_W  = $clog2(SEG_COUNT);
  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 16;
  localparam int LEN_W      = 16;
  localparam int ASIZE_W    = 5;
  localparam int CNT_W      = $clog2(ADDR_W);
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [SIZE_W-1:0] SEG_SIZE_RESET = SIZE_W'(64);

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_XLATE = 1'b1;

  // register select: bit 2 of the byte address
  localparam logic REG_MAX_SEG_SIZE = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_CHECK
  } sat_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } sat_div_stat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  length;
  } sat_entry_t;

endpackage
`default_nettype wire

/* hdl/sat_in_if.sv */
// Input channel: load and translate words
`default_nettype none
interface sat_in_if;
  import sat_pkg::*;

  logic               valid;
  logic               ready;
  logic               func;
  logic [SEG_IDX_W-1:0] entry_index;
  logic [ADDR_W-1:0]  entry_base;
  logic [LEN_W-1:0]   entry_length;
  logic [ADDR_W-1:0]  logical_address;
  logic [ASIZE_W-1:0] access_size;

  modport source (
    output valid, func, entry_index, entry_base, entry_length, logical_address, access_size,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, entry_base, entry_length, logical_address, access_size,
    output ready
  );
endinterface
`default_nettype wire

/* hdl/sat_out_if.sv */
// Output channel: translation result words
`default_nettype none
interface sat_out_if;
  import sat_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] physical_address;
  logic [ADDR_W-1:0] segment_number;
  logic [SIZE_W-1:0] segment_offset;
  logic              fault;

  modport source (
    output valid, physical_address, segment_number, segment_offset, fault,
    input  ready
  );
  modport sink (
    input  valid, physical_address, segment_number, segment_offset, fault,
    output ready
  );
endinterface
`default_nettype wire

/* hdl/sat_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle
`default_nettype none
module sat_divider (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [sat_pkg::ADDR_W-1:0] dividend_i,
  input  wire logic [sat_pkg::SIZE_W-1:0] divisor_i,
  output sat_pkg::sat_div_stat_t          stat_o,
  output logic [sat_pkg::ADDR_W-1:0]      quotient_o,
  output logic [sat_pkg::SIZE_W-1:0]      remainder_o
);
  import sat_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [ADDR_W-1:0]   quo_q, quo_d;
  logic [SIZE_W-1:0]   rem_q, rem_d;
  logic [SIZE_W:0]     trial;
  logic [SIZE_W:0]     diff;
  logic                qbit;

  always_comb begin
    trial  = {rem_q, quo_q[ADDR_W-1]};
    diff   = trial - {1'b0, divisor_i};
    qbit   = (trial >= {1'b0, divisor_i});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[ADDR_W-2:0], qbit};
      rem_d = qbit ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(ADDR_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule
`default_nettype wire

/* hdl/segment_address_translate.sv */
// Top level of the segment address translation block
//
// A load word writes one segment table entry in the cycle it is accepted and
// gives no result. A translate word goes through the bit-serial divider that
// splits the logical address by max_segment_size, then the registered table
// read and the limit check, and is loaded as a result once the output
// register is free. The result sits in an output register, so the next word
// is taken while the previous result waits. max_segment_size lives at byte
// address 0 of the APB port and resets to 64.
`default_nettype none
`include "segment_address_translate_assert.svh"
module segment_address_translate (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  sat_in_if.sink                           in_i,
  sat_out_if.source                        out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sat_pkg::PADDR_W-1:0] paddr,
  input  wire logic [sat_pkg::PDATA_W-1:0] pwdata,
  output logic [sat_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);
  import sat_pkg::*;

  sat_state_e           state_q, state_d;
  logic [SIZE_W-1:0]    seg_size_q;
  logic [SEG_COUNT-1:0] valid_q;
  sat_entry_t           table_mem [SEG_COUNT];
  sat_entry_t           rd_entry_q;
  logic [ASIZE_W-1:0]   asize_q;

  logic                 out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]    phys_q;
  logic [ADDR_W-1:0]    segno_q;
  logic [SIZE_W-1:0]    offs_q;
  logic                 fault_q;

  logic                 in_acc;
  logic                 load_acc;
  logic                 xlate_acc;
  logic                 out_acc;
  logic                 out_load;
  logic                 cfg_wr;

  sat_div_stat_t        div_stat;
  logic [ADDR_W-1:0]    quo;
  logic [SIZE_W-1:0]    rem;

  logic                 fault_d;
  logic [ADDR_W-1:0]    phys_d;
  logic [ADDR_W-1:0]    segno_d;
  logic [SIZE_W-1:0]    offs_d;
  logic [SIZE_W:0]      end_sum;

  assign in_acc    = in_i.valid && in_i.ready;
  assign load_acc  = in_acc && (in_i.func == FUNC_LOAD);
  assign xlate_acc = in_acc && (in_i.func == FUNC_XLATE);
  assign out_acc   = out_o.valid && out_o.ready;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_SEG_SIZE);
  assign prdata = (paddr[2] == REG_MAX_SEG_SIZE) ? PDATA_W'(seg_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_size_q <= SEG_SIZE_RESET;
    end else if (cfg_wr) begin
      seg_size_q <= pwdata[SIZE_W-1:0];
    end
  end

  sat_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (xlate_acc),
    .dividend_i  (in_i.logical_address),
    .divisor_i   (seg_size_q),
    .stat_o      (div_stat),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  // segment table
  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      table_mem[in_i.entry_index] <= '{base: in_i.entry_base, length: in_i.entry_length};
    end
    if (div_stat.done) begin
      rd_entry_q <= table_mem[quo[SEG_IDX_W-1:0]];
    end
    if (xlate_acc) begin
      asize_q <= in_i.access_size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (load_acc) begin
      valid_q[in_i.entry_index] <= 1'b1;
    end
  end

  // limit check
  always_comb begin
    end_sum = {1'b0, rem} + (SIZE_W + 1)'(asize_q);
    segno_d = quo;
    offs_d  = rem;
    fault_d = 1'b0;
    if (seg_size_q == '0) begin
      segno_d = '1;
      offs_d  = '0;
      fault_d = 1'b1;
    end else if (quo >= ADDR_W'(SEG_COUNT) || !valid_q[quo[SEG_IDX_W-1:0]]) begin
      fault_d = 1'b1;
    end else if (end_sum > {1'b0, rd_entry_q.length}) begin
      fault_d = 1'b1;
    end
    phys_d = fault_d ? '0 : rd_entry_q.base + ADDR_W'(rem);
  end

  // control
  always_comb begin
    state_d     = state_q;
    in_i.ready  = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_acc;
    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (xlate_acc) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!out_valid_q || out_acc) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      phys_q  <= phys_d;
      segno_q <= segno_d;
      offs_q  <= offs_d;
      fault_q <= fault_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.physical_address = phys_q;
  assign out_o.segment_number   = segno_q;
  assign out_o.segment_offset   = offs_q;
  assign out_o.fault            = fault_q;

  `SAT_ASSERT(a_idle_div_free, clk_i, rst_ni, in_i.ready |-> !div_stat.busy, "input taken while dividing")
  `SAT_ASSERT(a_done_to_check, clk_i, rst_ni, div_stat.done |=> state_q == S_CHECK, "divider done lost")
  `SAT_ASSERT(a_zero_size_fault, clk_i, rst_ni, (out_load && seg_size_q == '0) |=> (out_o.fault && out_o.physical_address == '0), "zero segment size must fault")
  `SAT_ASSERT(a_pass_in_table, clk_i, rst_ni, (out_load && !fault_d) |-> (quo < ADDR_W'(SEG_COUNT) && valid_q[quo[SEG_IDX_W-1:0]]), "translation passed on a bad segment")

endmodule
`default_nettype wire
